// File: hw/rtl/rssb_pkg.sv
`default_nettype none

package rssb_pkg;

    localparam int ELEMENT_DEPTH = 1024;
    localparam int BLOCK_LEN     = 32;
    localparam int BLOCK_COUNT   = (ELEMENT_DEPTH + BLOCK_LEN - 1) / BLOCK_LEN;

    localparam int ADDR_W  = $clog2(ELEMENT_DEPTH);
    localparam int OFS_W   = $clog2(BLOCK_LEN);
    localparam int BLK_W   = $clog2(BLOCK_COUNT);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 11;

    localparam int POS_LSB = 0;
    localparam int VAL_LSB = POS_LSB + ADDR_W;
    localparam int LO_LSB  = VAL_LSB + DATA_W;
    localparam int HI_LSB  = LO_LSB + ADDR_W;
    localparam int IN_TDATA_W = ((HI_LSB + ADDR_W + 7) / 8) * 8;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_ERR  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] pos;
        logic [DATA_W-1:0] val;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] total;
        logic              status;
    } t_res;

endpackage

`default_nettype wire

// File: hw/rtl/range_sum_sqrt_blocks_unit.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// s_*       in         s_tvalid / s_tready      request: tuser mode, tdata position etc.
// m_*       out        m_tvalid / m_tready      result: tdata range_total, tuser status
// cfg       in         i_cfg_valid/o_cfg_ready  active_count
//
// An update goes from the input register through S_IDLE and S_UPD to a
// waiting result in S_DONE. A query reads one element or one block sum per
// cycle from registered read ports: tail elements and whole middle blocks.
// After reset a clearing pass zeroes both stores; no request is taken
// meanwhile. One request is held while another is in work, and a
// finished result waits in the output register while m_tready is low.
module range_sum_sqrt_blocks_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // position, new_value, range_left, range_right, zero pad
    input  wire logic [rssb_pkg::IN_TDATA_W-1:0]     s_tdata,
    // mode
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // range_total
    output logic      [rssb_pkg::DATA_W-1:0]         m_tdata,
    // status
    output logic                                     m_tuser,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [rssb_pkg::CFG_W-1:0]          i_cfg_data
);

    import rssb_pkg::*;

    logic               r_in_full;
    t_req               r_req;
    logic               r_out_vld;
    t_res               r_out;
    logic [CFG_W-1:0]   r_active;

    logic               take;
    logic               clearing;
    logic               res_vld;
    t_res               res;
    logic               res_take;
    logic [CNT_W-1:0]   eff_count;
    logic               in_acc;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = !r_in_full && !clearing;
    assign in_acc      = s_tvalid && s_tready;
    assign res_take    = res_vld && (!r_out_vld || m_tready);
    assign eff_count   = (32'(r_active) > 32'(ELEMENT_DEPTH)) ? CNT_W'(ELEMENT_DEPTH)
                                                             : CNT_W'(r_active);

    rssb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_vld  (r_in_full),
        .i_req      (r_req),
        .o_take     (take),
        .i_count    (eff_count),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_take (res_take),
        .o_clearing (clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_full <= 1'b0;
            r_out_vld <= 1'b0;
            r_active  <= CFG_W'(ELEMENT_DEPTH);
        end else begin
            if (in_acc) begin
                r_in_full <= 1'b1;
            end else if (take) begin
                r_in_full <= 1'b0;
            end
            if (res_take) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req.mode <= s_tuser;
            r_req.pos  <= s_tdata[POS_LSB +: ADDR_W];
            r_req.val  <= s_tdata[VAL_LSB +: DATA_W];
            r_req.lo   <= s_tdata[LO_LSB +: ADDR_W];
            r_req.hi   <= s_tdata[HI_LSB +: ADDR_W];
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out.total;
    assign m_tuser  = r_out.status;

endmodule

`default_nettype wire

// File: hw/rtl/rssb_ram.sv
`default_nettype none

module rssb_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/rssb_seq.sv
`default_nettype none

module rssb_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_vld,
    input  wire rssb_pkg::t_req              i_req,
    output logic                             o_take,
    input  wire logic [rssb_pkg::CNT_W-1:0]  i_count,
    output logic                             o_res_vld,
    output rssb_pkg::t_res                   o_res,
    input  wire logic                        i_res_take,
    output logic                             o_clearing
);

    import rssb_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_UPD   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [ADDR_W-1:0]   r_hi, n_hi;
    logic [BLK_W-1:0]    r_br, n_br;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [DATA_W-1:0]   r_val, n_val;
    logic [DATA_W-1:0]   r_acc, n_acc;
    logic                r_err, n_err;
    logic                r_pend_vld, n_pend_vld;
    logic                r_pend_sel, n_pend_sel;
    logic                r_pend_last, n_pend_last;

    logic                elem_we;
    logic [ADDR_W-1:0]   elem_waddr;
    logic [DATA_W-1:0]   elem_wdata;
    logic [ADDR_W-1:0]   elem_raddr;
    logic [DATA_W-1:0]   elem_rdata;
    logic                bsum_we;
    logic [BLK_W-1:0]    bsum_waddr;
    logic [DATA_W-1:0]   bsum_wdata;
    logic [BLK_W-1:0]    bsum_raddr;
    logic [DATA_W-1:0]   bsum_rdata;

    logic [ADDR_W-1:0]   cur;
    logic [BLK_W-1:0]    cur_blk;
    logic                whole;
    logic [CNT_W-1:0]    nxt;
    logic                last;
    logic                upd_err;
    logic                qry_err;

    rssb_ram #(.DEPTH(ELEMENT_DEPTH), .WIDTH(DATA_W)) u_elem (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (elem_waddr),
        .i_wdata (elem_wdata),
        .i_raddr (elem_raddr),
        .o_rdata (elem_rdata)
    );

    rssb_ram #(.DEPTH(BLOCK_COUNT), .WIDTH(DATA_W)) u_bsum (
        .i_clk   (i_clk),
        .i_we    (bsum_we),
        .i_waddr (bsum_waddr),
        .i_wdata (bsum_wdata),
        .i_raddr (bsum_raddr),
        .o_rdata (bsum_rdata)
    );

    assign cur     = r_idx[ADDR_W-1:0];
    assign cur_blk = cur[ADDR_W-1:OFS_W];
    assign whole   = (cur[OFS_W-1:0] == '0) && (cur_blk < r_br);
    assign nxt     = r_idx + (whole ? CNT_W'(BLOCK_LEN) : CNT_W'(1));
    assign last    = nxt > {1'b0, r_hi};
    assign upd_err = {1'b0, i_req.pos} >= i_count;
    assign qry_err = (i_req.lo > i_req.hi) || ({1'b0, i_req.hi} >= i_count);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_hi        = r_hi;
        n_br        = r_br;
        n_pos       = r_pos;
        n_val       = r_val;
        n_acc       = r_acc;
        n_err       = r_err;
        n_pend_vld  = 1'b0;
        n_pend_sel  = r_pend_sel;
        n_pend_last = r_pend_last;
        o_take      = 1'b0;
        elem_we     = 1'b0;
        elem_waddr  = r_pos;
        elem_wdata  = r_val;
        elem_raddr  = cur;
        bsum_we     = 1'b0;
        bsum_waddr  = r_pos[ADDR_W-1:OFS_W];
        bsum_wdata  = bsum_rdata + r_val - elem_rdata;
        bsum_raddr  = cur_blk;
        unique case (r_state)
            S_CLEAR: begin
                elem_we    = 1'b1;
                elem_waddr = cur;
                elem_wdata = '0;
                bsum_we    = 1'b1;
                bsum_waddr = r_idx[BLK_W-1:0];
                bsum_wdata = '0;
                if (r_idx == CNT_W'(ELEMENT_DEPTH - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (i_req_vld) begin
                    o_take = 1'b1;
                    n_acc  = '0;
                    n_err  = STATUS_OK;
                    if (i_req.mode == MODE_UPDATE) begin
                        if (upd_err) begin
                            n_err   = STATUS_ERR;
                            n_state = S_DONE;
                        end else begin
                            elem_raddr = i_req.pos;
                            bsum_raddr = i_req.pos[ADDR_W-1:OFS_W];
                            n_pos      = i_req.pos;
                            n_val      = i_req.val;
                            n_state    = S_UPD;
                        end
                    end else begin
                        if (qry_err) begin
                            n_err   = STATUS_ERR;
                            n_state = S_DONE;
                        end else begin
                            n_idx   = {1'b0, i_req.lo};
                            n_hi    = i_req.hi;
                            n_br    = i_req.hi[ADDR_W-1:OFS_W];
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_UPD: begin
                elem_we = 1'b1;
                bsum_we = 1'b1;
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (r_pend_vld) begin
                    n_acc = r_acc + (r_pend_sel ? bsum_rdata : elem_rdata);
                end
                n_pend_vld  = 1'b1;
                n_pend_sel  = whole;
                n_pend_last = last;
                n_idx       = nxt;
                if (last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_acc   = r_acc + (r_pend_sel ? bsum_rdata : elem_rdata);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_err      <= STATUS_OK;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_pend_vld <= n_pend_vld;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi        <= n_hi;
        r_br        <= n_br;
        r_pos       <= n_pos;
        r_val       <= n_val;
        r_acc       <= n_acc;
        r_pend_sel  <= n_pend_sel;
        r_pend_last <= n_pend_last;
    end

    assign o_res_vld  = (r_state == S_DONE);
    assign o_res      = '{total: r_acc, status: r_err};
    assign o_clearing = (r_state == S_CLEAR);

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_res.status == STATUS_ERR) |-> (o_res.total == '0))
        else $error("error result carries a nonzero total");

    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_DRAIN) |-> (!elem_we && !bsum_we))
        else $error("store written during a query scan");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (r_state == S_IDLE))
        else $error("request taken while busy");

    a_upd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state == S_DONE))
        else $error("update write-back did not finish");

    a_drain_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_pend_vld && r_pend_last))
        else $error("drain without a final pending read");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rssb_pkg::*;

    localparam int QUIET_LIMIT = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic                  m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    range_sum_sqrt_blocks_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the element store, per-block sums and element count
    logic [DATA_W-1:0] elem_shadow [ELEMENT_DEPTH] = '{default: '0};
    logic [DATA_W-1:0] block_shadow [BLOCK_COUNT] = '{default: '0};
    logic [CFG_W-1:0]  cfg_active_count = CFG_W'(1024);

    t_req        request_queue [$];
    t_res        pending_sums [$];
    int unsigned tx_idle_pct = 36;
    int unsigned rx_idle_pct = 77;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    function automatic void queue_request(t_req r);
        request_queue = {request_queue, r};
    endfunction

    function automatic void queue_result(t_res r);
        pending_sums = {pending_sums, r};
    endfunction

    function automatic int unsigned usable_count();
        return (cfg_active_count > ELEMENT_DEPTH) ? ELEMENT_DEPTH : int'(cfg_active_count);
    endfunction

    function automatic t_res apply_request(t_req r);
        t_res        res;
        int unsigned lim;
        int          lo_blk;
        int          hi_blk;
        logic [DATA_W-1:0] acc;
        lim = usable_count();
        res.total  = '0;
        res.status = STATUS_OK;
        acc = '0;
        if (r.mode == MODE_UPDATE) begin
            if (r.pos >= lim) begin
                res.status = STATUS_ERR;
            end else begin
                block_shadow[r.pos / BLOCK_LEN] += r.val - elem_shadow[r.pos];
                elem_shadow[r.pos] = r.val;
            end
        end else if (r.lo > r.hi || r.hi >= lim) begin
            res.status = STATUS_ERR;
        end else begin
            lo_blk = r.lo / BLOCK_LEN;
            hi_blk = r.hi / BLOCK_LEN;
            if (lo_blk == hi_blk) begin
                for (int i = r.lo; i <= r.hi; i++) acc += elem_shadow[i];
            end else begin
                for (int i = r.lo; i < (lo_blk + 1) * BLOCK_LEN; i++) acc += elem_shadow[i];
                for (int i = hi_blk * BLOCK_LEN; i <= r.hi; i++) acc += elem_shadow[i];
                for (int b = lo_blk + 1; b < hi_blk; b++) acc += block_shadow[b];
            end
            res.total = acc;
        end
        return res;
    endfunction

    function automatic t_req random_request(int unsigned lim);
        t_req        r;
        int unsigned pick;
        int unsigned lo_i;
        int unsigned hi_i;
        r.mode = 1'($urandom_range(0, 1));
        r.pos  = ADDR_W'($urandom);
        r.lo   = ADDR_W'($urandom);
        r.hi   = ADDR_W'($urandom);
        case ($urandom_range(0, 7))
            0: r.val = 32'h8000_0000;
            1: r.val = 32'h7FFF_FFFF;
            2: r.val = 32'hFFFF_FFFF;
            3: r.val = 32'h0000_0000;
            default: r.val = $urandom;
        endcase
        pick = $urandom_range(0, 99);
        if (lim != 0 && pick < 90) begin
            if (r.mode == MODE_UPDATE) begin
                r.pos = ADDR_W'($urandom_range(0, lim - 1));
            end else begin
                lo_i = $urandom_range(0, lim - 1);
                if (pick < 45) begin
                    hi_i = lo_i + $urandom_range(0, BLOCK_LEN);
                    if (hi_i > lim - 1) hi_i = lim - 1;
                end else begin
                    hi_i = $urandom_range(lo_i, lim - 1);
                end
                r.lo = ADDR_W'(lo_i);
                r.hi = ADDR_W'(hi_i);
            end
        end
        return r;
    endfunction

    task automatic push_update(int unsigned pos, logic [DATA_W-1:0] val);
        t_req r;
        r = random_request(0);
        r.mode = MODE_UPDATE;
        r.pos  = ADDR_W'(pos);
        r.val  = val;
        queue_request(r);
    endtask

    task automatic push_query(int unsigned lo, int unsigned hi);
        t_req r;
        r = random_request(0);
        r.mode = MODE_QUERY;
        r.lo   = ADDR_W'(lo);
        r.hi   = ADDR_W'(hi);
        queue_request(r);
    endtask

    task automatic write_active_count(logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_active_count = value;
    endtask

    task automatic drain();
        while (request_queue.size() != 0 || s_tvalid || pending_sums.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic note_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge i_clk) begin : drive
        t_req              held;
        logic [IN_TDATA_W-1:0] word;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) queue_result(apply_request(held));
            if (!s_tvalid || s_tready) begin
                if (request_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    held = request_queue.pop_front();
                    word = '0;
                    word[POS_LSB +: ADDR_W] = held.pos;
                    word[VAL_LSB +: DATA_W] = held.val;
                    word[LO_LSB +: ADDR_W]  = held.lo;
                    word[HI_LSB +: ADDR_W]  = held.hi;
                    s_tdata  <= word;
                    s_tuser  <= held.mode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : observe
        t_res want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_sums.size() == 0) begin
                    note_mismatch("unexpected result", '0, m_tdata);
                end else begin
                    want = pending_sums.pop_front();
                    if (m_tdata !== want.total) note_mismatch("range_total", want.total, m_tdata);
                    if (m_tuser !== want.status)
                        note_mismatch("status", DATA_W'(want.status), DATA_W'(m_tuser));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("** range_sum_sqrt_blocks_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned lim;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_active_count(CFG_W'(1024));
        push_update(0, 32'h7FFF_FFFF);
        push_update(1023, 32'h8000_0000);
        push_update(31, 32'd5);
        push_update(32, 32'hFFFF_FFFF);
        push_update(0, 32'h1234_5678);
        push_query(0, 0);
        push_query(0, 1023);
        push_query(1023, 1023);
        push_query(31, 32);
        push_query(3, 20);
        push_query(10, 1000);
        push_query(5, 4);
        push_update(1023, 32'h0000_0000);
        push_query(0, 1023);
        drain();

        write_active_count(CFG_W'(1));
        push_update(0, 32'hFFFF_FFFF);
        push_update(1, 32'd7);
        push_query(0, 0);
        push_query(0, 1);
        drain();

        write_active_count(CFG_W'(0));
        push_update(0, 32'd9);
        push_query(0, 0);
        drain();

        write_active_count(CFG_W'(2047));
        push_update(1023, 32'd3);
        push_query(0, 1023);
        push_query(1000, 1023);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 77 : 0;
            rx_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 36 : 0;
            write_active_count((ph == 1) ? CFG_W'($urandom_range(2, 1023)) : CFG_W'(1024));
            lim = usable_count();
            repeat (167) queue_request(random_request(lim));
            drain();
        end

        repeat (100) @(posedge i_clk);
        mismatches += pending_sums.size();
        if (mismatches == 0)
            $display("** range_sum_sqrt_blocks_unit: PASSED **");
        else
            $display("** range_sum_sqrt_blocks_unit: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rssb_pkg.sv
hw/rtl/rssb_ram.sv
hw/rtl/rssb_seq.sv
hw/rtl/range_sum_sqrt_blocks_unit.sv
verif/tb_top.sv
